[src/lrc_pkg.sv]
// Shared types and constants of the line and rectangle clip engine.
// Used by line_rect_clip_engine_top and lrc_checker; no dependencies.

package lrc_pkg;

	// Coordinates and register data
	localparam int COORD_W = 16;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Coordinate differences need one extra bit
	localparam int DIFF_W = COORD_W + 1;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Exact product of two differences
	localparam int PROD_W = 2 * DIFF_W;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Divider steps: one quotient bit per step
	localparam int DIV_CNT_W = $clog2(PROD_W);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_SOFT_ONLY = 3'd5;

	// Region outcode bits
	typedef logic [3:0] outcode_t;
	localparam outcode_t OC_NONE   = 4'd0;
	localparam outcode_t OC_LEFT   = 4'd1;
	localparam outcode_t OC_RIGHT  = 4'd2;
	localparam outcode_t OC_TOP    = 4'd4;
	localparam outcode_t OC_BOTTOM = 4'd8;

	// Outcode rounds before a diagonal is given up
	localparam int CS_ROUNDS = 16;
	localparam int ROUND_W   = $clog2(CS_ROUNDS + 1);

	// Command codes
	localparam logic CMD_LINE = 1'b0;
	localparam logic CMD_RECT = 1'b1;

endpackage

[src/line_rect_clip_engine_top.sv]
// Line and rectangle clip engine: clips one primitive per item against the
// configured clip box. Depends on lrc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one primitive: cmd selects a
//   line or a filled rectangle, start/end give its coordinates. Output
//   channel (out_valid/out_ready) returns one result per item: visible and
//   the clipped coordinates, all zero when rejected.
//   Clip box and mode bits are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the engine is idle, as the block
//   does not enforce it; writes then take effect on the next item.
//   Flow: rectangles, axis-aligned lines and unclipped primitives go from
//   S_PREP straight to S_FIN. A diagonal clipped in soft-only mode runs up
//   to 16 outcode rounds (at most 4 for any reachable input). Each round
//   runs one registered multiply and a 34-step restoring divider, one
//   quotient bit per cycle. One item is in work at a time: in_ready is
//   high only while the sequencer idles.
//   A finished result sits in the output register; while the receiver
//   stalls, the next item may be accepted and processed, and it waits in
//   its final state until the output register frees up.
//   Reset (arst_n low) clears all clip registers to zero, drops any item in
//   work and empties the output register.

module line_rect_clip_engine_top
	import lrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	// Input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  coord_t               start_x,
	input  coord_t               start_y,
	input  coord_t               end_x,
	input  coord_t               end_y,
	// Result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 visible,
	output coord_t               out_start_x,
	output coord_t               out_start_y,
	output coord_t               out_end_x,
	output coord_t               out_end_y
);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_CODE = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ABS  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_UPD  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;

	// Clip registers
	coord_t min_x_q, min_y_q, max_x_q, max_y_q;
	logic   enable_q, soft_q;

	// Working endpoints
	logic   cmd_q, vis_q;
	coord_t x1_q, y1_q, x2_q, y2_q;

	// Intersection operands
	coord_t edge_q, base_q;
	diff_t  num_q, frac_q, den_q;
	logic   xedge_q, side1_q;
	logic [ROUND_W-1:0] round_q;

	// Multiplier and divider registers
	prod_t                prod_q;
	logic [COORD_W-1:0]   den_mag_q;
	logic                 neg_den_q, den_zero_q, neg_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [COORD_W-1:0]   rem_q;
	logic [COORD_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] bit_cnt_q;

	// Output register
	logic   out_valid_q, out_vis_q;
	coord_t out_x1_q, out_y1_q, out_x2_q, out_y2_q;

	logic load_out;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign visible     = out_vis_q;
	assign out_start_x = out_x1_q;
	assign out_start_y = out_y1_q;
	assign out_end_x   = out_x2_q;
	assign out_end_y   = out_y2_q;
	assign load_out    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Box step: sort line corners, clamp to the clip box, classify
	coord_t ra_x, rb_x, ra_y, rb_y;
	coord_t ka_x, kb_x, ka_y, kb_y;
	logic   box_ok, inverted;
	logic   p_vis, p_diag;
	coord_t p_x1, p_y1, p_x2, p_y2;

	always_comb begin
		if (cmd_q == CMD_RECT || x1_q < x2_q) begin
			ra_x = x1_q;
			rb_x = x2_q;
		end else begin
			ra_x = x2_q;
			rb_x = x1_q;
		end
		if (cmd_q == CMD_RECT || y1_q < y2_q) begin
			ra_y = y1_q;
			rb_y = y2_q;
		end else begin
			ra_y = y2_q;
			rb_y = y1_q;
		end
		ka_x     = (ra_x < min_x_q) ? min_x_q : ra_x;
		ka_y     = (ra_y < min_y_q) ? min_y_q : ra_y;
		kb_x     = (rb_x > max_x_q) ? max_x_q : rb_x;
		kb_y     = (rb_y > max_y_q) ? max_y_q : rb_y;
		box_ok   = (kb_x >= ka_x) && (kb_y >= ka_y);
		inverted = (x2_q < x1_q) || (y2_q < y1_q);

		p_vis  = 1'b1;
		p_diag = 1'b0;
		p_x1   = x1_q;
		p_y1   = y1_q;
		p_x2   = x2_q;
		p_y2   = y2_q;
		if (cmd_q == CMD_RECT) begin
			if (inverted) begin
				p_vis = 1'b0;
			end else if (enable_q) begin
				p_vis = box_ok;
				p_x1  = ka_x;
				p_y1  = ka_y;
				p_x2  = kb_x;
				p_y2  = kb_y;
			end
		end else if (enable_q) begin
			if (!box_ok) begin
				p_vis = 1'b0;
			end else if (y1_q == y2_q) begin
				// horizontal or point: sorted x, common y
				p_x1 = ka_x;
				p_y1 = ka_y;
				p_x2 = kb_x;
				p_y2 = ka_y;
			end else if (x1_q == x2_q) begin
				p_x1 = ka_x;
				p_y1 = ka_y;
				p_x2 = ka_x;
				p_y2 = kb_y;
			end else if (soft_q) begin
				p_diag = 1'b1;
			end
		end
	end

	// Outcodes of both endpoints and the edge to cut next
	outcode_t c1, c2, csel;
	diff_t    dx, dy;
	coord_t   n_edge, n_base;
	diff_t    n_num, n_frac, n_den;
	logic     n_xedge;

	function automatic outcode_t region(coord_t x, coord_t y, coord_t lx, coord_t ly,
			coord_t hx, coord_t hy);
		outcode_t c;
		c = OC_NONE;
		if (x < lx) c = c | OC_LEFT;
		else if (x > hx) c = c | OC_RIGHT;
		if (y < ly) c = c | OC_TOP;
		else if (y > hy) c = c | OC_BOTTOM;
		return c;
	endfunction

	always_comb begin
		c1   = region(x1_q, y1_q, min_x_q, min_y_q, max_x_q, max_y_q);
		c2   = region(x2_q, y2_q, min_x_q, min_y_q, max_x_q, max_y_q);
		csel = (c1 != OC_NONE) ? c1 : c2;
		dx   = {x2_q[COORD_W-1], x2_q} - {x1_q[COORD_W-1], x1_q};
		dy   = {y2_q[COORD_W-1], y2_q} - {y1_q[COORD_W-1], y1_q};
		if ((csel & OC_LEFT) != OC_NONE) begin
			n_edge  = min_x_q;
			n_xedge = 1'b1;
		end else if ((csel & OC_RIGHT) != OC_NONE) begin
			n_edge  = max_x_q;
			n_xedge = 1'b1;
		end else if ((csel & OC_TOP) != OC_NONE) begin
			n_edge  = min_y_q;
			n_xedge = 1'b0;
		end else begin
			n_edge  = max_y_q;
			n_xedge = 1'b0;
		end
		if (n_xedge) begin
			n_num  = dy;
			n_den  = dx;
			n_base = y1_q;
			n_frac = {n_edge[COORD_W-1], n_edge} - {x1_q[COORD_W-1], x1_q};
		end else begin
			n_num  = dx;
			n_den  = dy;
			n_base = x1_q;
			n_frac = {n_edge[COORD_W-1], n_edge} - {y1_q[COORD_W-1], y1_q};
		end
	end

	// Divider step and final coordinate
	logic [COORD_W:0]   shifted;
	logic [COORD_W+1:0] trial;
	logic               qbit;
	diff_t              den_abs;
	prod_t              prod_abs;
	logic [COORD_W-1:0] quo_signed;
	coord_t             new_c;

	always_comb begin
		shifted    = {rem_q, dvd_q[PROD_W-1]};
		trial      = {1'b0, shifted} - {2'b00, den_mag_q};
		qbit       = !trial[COORD_W+1];
		den_abs    = den_q[DIFF_W-1] ? -den_q : den_q;
		prod_abs   = prod_q[PROD_W-1] ? -prod_q : prod_q;
		if (den_zero_q) quo_signed = '0;
		else if (neg_q) quo_signed = -quo_q;
		else quo_signed = quo_q;
		new_c      = base_q + coord_t'(quo_signed);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= '0;
			min_y_q  <= '0;
			max_x_q  <= '0;
			max_y_q  <= '0;
			enable_q <= 1'b0;
			soft_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_MIN_X:     min_x_q  <= cfg_data;
				REG_CLIP_MIN_Y:     min_y_q  <= cfg_data;
				REG_CLIP_MAX_X:     max_x_q  <= cfg_data;
				REG_CLIP_MAX_Y:     max_y_q  <= cfg_data;
				REG_CLIP_ENABLE:    enable_q <= cfg_data[0];
				REG_CLIP_SOFT_ONLY: soft_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			round_q   <= '0;
			bit_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_PREP;
				S_PREP: begin
					round_q <= '0;
					state_q <= p_diag ? S_CODE : S_FIN;
				end
				S_CODE: begin
					if (round_q == ROUND_W'(CS_ROUNDS)) state_q <= S_FIN;
					else if ((c1 | c2) == OC_NONE) state_q <= S_FIN;
					else if ((c1 & c2) != OC_NONE) state_q <= S_FIN;
					else state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ABS;
				S_ABS: begin
					bit_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == DIV_CNT_W'(PROD_W - 1)) state_q <= S_UPD;
				end
				S_UPD: begin
					round_q <= round_q + 1'b1;
					state_q <= S_CODE;
				end
				S_FIN: if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: capture, box step, outcode rounds, multiply, divide, update
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q <= cmd;
					x1_q  <= start_x;
					y1_q  <= start_y;
					x2_q  <= end_x;
					y2_q  <= end_y;
				end
			end
			S_PREP: begin
				vis_q <= p_vis;
				x1_q  <= p_x1;
				y1_q  <= p_y1;
				x2_q  <= p_x2;
				y2_q  <= p_y2;
			end
			S_CODE: begin
				// accept inside, drop when both share an outside region or out of rounds
				if (round_q == ROUND_W'(CS_ROUNDS)) vis_q <= 1'b0;
				else if ((c1 | c2) == OC_NONE) vis_q <= 1'b1;
				else if ((c1 & c2) != OC_NONE) vis_q <= 1'b0;
				edge_q  <= n_edge;
				base_q  <= n_base;
				num_q   <= n_num;
				frac_q  <= n_frac;
				den_q   <= n_den;
				xedge_q <= n_xedge;
				side1_q <= (c1 != OC_NONE);
			end
			S_MUL: begin
				prod_q     <= num_q * frac_q;
				den_mag_q  <= den_abs[COORD_W-1:0];
				neg_den_q  <= den_q[DIFF_W-1];
				den_zero_q <= (den_q == '0);
			end
			S_ABS: begin
				neg_q <= prod_q[PROD_W-1] ^ neg_den_q;
				dvd_q <= prod_abs;
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				// restoring step: shift in one dividend bit, subtract if it fits
				dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
				rem_q <= qbit ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], qbit};
			end
			S_UPD: begin
				if (side1_q) begin
					x1_q <= xedge_q ? edge_q : new_c;
					y1_q <= xedge_q ? new_c : edge_q;
				end else begin
					x2_q <= xedge_q ? edge_q : new_c;
					y2_q <= xedge_q ? new_c : edge_q;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold until taken, zero coordinates on reject
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_vis_q <= vis_q;
			out_x1_q  <= vis_q ? x1_q : '0;
			out_y1_q  <= vis_q ? y1_q : '0;
			out_x2_q  <= vis_q ? x2_q : '0;
			out_y2_q  <= vis_q ? y2_q : '0;
		end
	end

endmodule

[src/lrc_checker.sv]
// Port-level checks of the line and rectangle clip engine, bound to
// line_rect_clip_engine_top. Depends on lrc_pkg.

module lrc_checker
	import lrc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 visible,
	input coord_t               out_start_x,
	input coord_t               out_start_y,
	input coord_t               out_end_x,
	input coord_t               out_end_y
);

	// Engine goes busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an item was taken");

	// A result never appears in the cycle right after an item is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared too early after acceptance");

	// Rejected primitives carry all-zero coordinates
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> out_start_x == '0 && out_start_y == '0 &&
			out_end_x == '0 && out_end_y == '0)
		else $error("rejected item has nonzero coordinates");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(visible) &&
			$stable(out_start_x) && $stable(out_start_y) &&
			$stable(out_end_x) && $stable(out_end_y))
		else $error("stalled result changed");

endmodule

bind line_rect_clip_engine_top lrc_checker u_lrc_checker (.*);

[tb/line_rect_clip_engine_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for line_rect_clip_engine_top: predicts every clipped
// primitive and checks it against the block. Depends on lrc_pkg and the RTL only.

module line_rect_clip_engine_top_test;
	import lrc_pkg::*;

	localparam int RESET_CYCLES   = 3;
	localparam int RANDOM_ITEMS   = 70;
	localparam int PRESSURE_ITEMS = 40;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 200;
	localparam int LIMIT_CYCLES   = 1000000;

	typedef struct packed {
		logic   cmd;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} prim_t;

	typedef struct packed {
		logic   visible;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} clip_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CLIP_MIN_X;
	logic [COORD_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd = CMD_LINE;
	coord_t               start_x = '0;
	coord_t               start_y = '0;
	coord_t               end_x = '0;
	coord_t               end_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 visible;
	coord_t               out_start_x;
	coord_t               out_start_y;
	coord_t               out_end_x;
	coord_t               out_end_y;

	// Local copy of the clip registers
	int   clip_lo_x = 0;
	int   clip_lo_y = 0;
	int   clip_hi_x = 0;
	int   clip_hi_y = 0;
	logic clip_on = 1'b0;
	logic clip_exact = 1'b0;

	prim_t     prim_q[$];
	clip_res_t clipped_q[$];
	prim_t     cur_prim;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_req = 0;
	int        hold_ack = 0;
	int        hold_left = 0;
	int        mismatches = 0;
	int unsigned cycle_cnt = 0;

	line_rect_clip_engine_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.visible     (visible),
		.out_start_x (out_start_x),
		.out_start_y (out_start_y),
		.out_end_x   (out_end_x),
		.out_end_y   (out_end_y)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic outcode_t region_of(int x, int y);
		outcode_t c;
		c = OC_NONE;
		if (x < clip_lo_x) c |= OC_LEFT;
		else if (x > clip_hi_x) c |= OC_RIGHT;
		if (y < clip_lo_y) c |= OC_TOP;
		else if (y > clip_hi_y) c |= OC_BOTTOM;
		return c;
	endfunction

	// base + num*frac/den with an exact product, truncating toward zero
	function automatic int edge_hit(int base, int num, int frac, int den);
		longint p;
		p = longint'(num) * longint'(frac);
		if (den == 0) return base;
		return int'(longint'(base) + p / longint'(den));
	endfunction

	function automatic logic box_overlap(inout int xa, inout int ya, inout int xb, inout int yb);
		if (xa < clip_lo_x) xa = clip_lo_x;
		if (ya < clip_lo_y) ya = clip_lo_y;
		if (xb > clip_hi_x) xb = clip_hi_x;
		if (yb > clip_hi_y) yb = clip_hi_y;
		return (xb >= xa) && (yb >= ya);
	endfunction

	// Iterate outcodes, moving the outside endpoint onto one edge per round
	function automatic logic trim_diagonal(inout int x1, inout int y1, inout int x2, inout int y2);
		outcode_t c1, c2, c;
		int dx, dy, nx, ny, r;
		for (r = 0; r < CS_ROUNDS; r++) begin
			c1 = region_of(x1, y1);
			c2 = region_of(x2, y2);
			if ((c1 | c2) == OC_NONE) return 1'b1;
			if ((c1 & c2) != OC_NONE) return 1'b0;
			dx = x2 - x1;
			dy = y2 - y1;
			c = (c1 != OC_NONE) ? c1 : c2;
			if ((c & OC_LEFT) != OC_NONE) begin
				nx = clip_lo_x;
				ny = edge_hit(y1, dy, clip_lo_x - x1, dx);
			end else if ((c & OC_RIGHT) != OC_NONE) begin
				nx = clip_hi_x;
				ny = edge_hit(y1, dy, clip_hi_x - x1, dx);
			end else if ((c & OC_TOP) != OC_NONE) begin
				ny = clip_lo_y;
				nx = edge_hit(x1, dx, clip_lo_y - y1, dy);
			end else begin
				ny = clip_hi_y;
				nx = edge_hit(x1, dx, clip_hi_y - y1, dy);
			end
			nx = int'(coord_t'(nx));
			ny = int'(coord_t'(ny));
			if (c1 != OC_NONE) begin
				x1 = nx;
				y1 = ny;
			end else begin
				x2 = nx;
				y2 = ny;
			end
		end
		return 1'b0;
	endfunction

	function automatic clip_res_t clip_primitive(prim_t p);
		int x1, y1, x2, y2, xa, ya, xb, yb;
		logic vis;
		clip_res_t r;
		x1 = $signed(p.sx);
		y1 = $signed(p.sy);
		x2 = $signed(p.ex);
		y2 = $signed(p.ey);
		vis = 1'b1;
		if (p.cmd == CMD_RECT) begin
			if (x2 < x1 || y2 < y1) vis = 1'b0;
			else if (clip_on) vis = box_overlap(x1, y1, x2, y2);
		end else if (clip_on) begin
			xa = (x1 < x2) ? x1 : x2;
			xb = (x1 < x2) ? x2 : x1;
			ya = (y1 < y2) ? y1 : y2;
			yb = (y1 < y2) ? y2 : y1;
			if (!box_overlap(xa, ya, xb, yb)) begin
				vis = 1'b0;
			end else if (y1 == y2) begin
				x1 = xa;
				x2 = xb;
				y1 = ya;
				y2 = ya;
			end else if (x1 == x2) begin
				x1 = xa;
				x2 = xa;
				y1 = ya;
				y2 = yb;
			end else if (clip_exact) begin
				vis = trim_diagonal(x1, y1, x2, y2);
			end
		end
		r.visible = vis;
		r.sx = vis ? coord_t'(x1) : '0;
		r.sy = vis ? coord_t'(y1) : '0;
		r.ex = vis ? coord_t'(x2) : '0;
		r.ey = vis ? coord_t'(y2) : '0;
		return r;
	endfunction

	// ---------------------------------------------------------------- driver

	// Hold the item until accepted, then offer the next one unless idling
	always @(posedge clk) begin : feed
		logic accepted;
		logic next_valid;
		accepted = in_valid && in_ready;
		if (accepted) clipped_q.push_back(clip_primitive(cur_prim));
		next_valid = in_valid && !accepted;
		if (!next_valid && arst_n && prim_q.size() != 0 &&
		    $urandom_range(0, 99) >= send_idle_pct) begin
			cur_prim = prim_q.pop_front();
			cmd <= cur_prim.cmd;
			start_x <= cur_prim.sx;
			start_y <= cur_prim.sy;
			end_x <= cur_prim.ex;
			end_y <= cur_prim.ey;
			next_valid = 1'b1;
		end
		in_valid <= next_valid;
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(string name, coord_t want, coord_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result with the oldest expectation, then pick the stall
	always @(posedge clk) begin : watch
		clip_res_t want;
		if (out_valid && out_ready) begin
			if (clipped_q.size() == 0) begin
				$error("unexpected result: visible %0b start (%0d,%0d) end (%0d,%0d)",
				       visible, out_start_x, out_start_y, out_end_x, out_end_y);
				mismatches++;
			end else begin
				want = clipped_q.pop_front();
				check_field("visible", coord_t'(want.visible), coord_t'(visible));
				check_field("out_start_x", want.sx, out_start_x);
				check_field("out_start_y", want.sy, out_start_y);
				check_field("out_end_x", want.ex, out_end_x);
				check_field("out_end_y", want.ey, out_end_y);
			end
		end
		if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= coord_t'(val);
	endtask

	// Write all six registers; only called while the block is idle
	task automatic set_clip(int lx, int ly, int hx, int hy, logic en, logic exact);
		clip_lo_x = lx;
		clip_lo_y = ly;
		clip_hi_x = hx;
		clip_hi_y = hy;
		clip_on = en;
		clip_exact = exact;
		write_reg(REG_CLIP_MIN_X, lx);
		write_reg(REG_CLIP_MIN_Y, ly);
		write_reg(REG_CLIP_MAX_X, hx);
		write_reg(REG_CLIP_MAX_Y, hy);
		write_reg(REG_CLIP_ENABLE, int'(en));
		write_reg(REG_CLIP_SOFT_ONLY, int'(exact));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_prim(logic c, int sx, int sy, int ex, int ey);
		prim_t p;
		p.cmd = c;
		p.sx = coord_t'(sx);
		p.sy = coord_t'(sy);
		p.ex = coord_t'(ex);
		p.ey = coord_t'(ey);
		prim_q.push_back(p);
	endtask

	// Wait until every item is in and every result is out, then settle
	task automatic drain();
		do @(negedge clk);
		while (prim_q.size() != 0 || in_valid || clipped_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly within 40 of the clip range, sometimes anywhere in the 16-bit range
	function automatic coord_t near_coord(int lo, int hi);
		int a, b;
		if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
		a = ((lo < hi) ? lo : hi) - 40;
		b = ((lo < hi) ? hi : lo) + 40;
		if (a < -32768) a = -32768;
		if (b > 32767) b = 32767;
		return coord_t'(a + int'($urandom_range(0, b - a)));
	endfunction

	function automatic prim_t random_prim();
		prim_t p;
		coord_t t;
		int kind;
		kind = $urandom_range(0, 9);
		p.sx = near_coord(clip_lo_x, clip_hi_x);
		p.sy = near_coord(clip_lo_y, clip_hi_y);
		p.ex = near_coord(clip_lo_x, clip_hi_x);
		p.ey = near_coord(clip_lo_y, clip_hi_y);
		if (kind < 3) begin
			p.cmd = CMD_RECT;
			// keep most rectangles upright
			if ($urandom_range(0, 6) != 0) begin
				if ($signed(p.ex) < $signed(p.sx)) begin
					t = p.ex;
					p.ex = p.sx;
					p.sx = t;
				end
				if ($signed(p.ey) < $signed(p.sy)) begin
					t = p.ey;
					p.ey = p.sy;
					p.sy = t;
				end
			end
		end else begin
			p.cmd = CMD_LINE;
			if (kind == 3) p.ey = p.sy;
			else if (kind == 4) p.ex = p.sx;
			else if (kind == 5) begin
				p.ex = p.sx;
				p.ey = p.sy;
			end
		end
		return p;
	endfunction

	task automatic random_phase(int lx, int ly, int hx, int hy, logic en, logic exact,
	                            int send_pct, int recv_pct);
		int i;
		set_clip(lx, ly, hx, hy, en, exact);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (i = 0; i < RANDOM_ITEMS; i++) prim_q.push_back(random_prim());
		drain();
	endtask

	initial begin
		int bx, by, i;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Clipping off after reset: lines pass, inverted rectangles still drop
		queue_prim(CMD_LINE, 1, 2, 3, 4);
		queue_prim(CMD_RECT, 10, 0, 5, 5);
		queue_prim(CMD_RECT, -32768, -32768, 32767, 32767);
		drain();

		// Exact clipping against a small box
		set_clip(-100, -50, 200, 150, 1'b1, 1'b1);
		queue_prim(CMD_RECT, 0, 0, 50, 50);
		queue_prim(CMD_RECT, -300, -300, 100, 100);
		queue_prim(CMD_RECT, 300, 0, 400, 50);
		queue_prim(CMD_RECT, 0, 50, 10, 40);
		queue_prim(CMD_LINE, 500, 10, -500, 10);
		queue_prim(CMD_LINE, 20, 400, 20, -400);
		queue_prim(CMD_LINE, 5, 5, 5, 5);
		queue_prim(CMD_LINE, 500, 500, 500, 500);
		queue_prim(CMD_LINE, 0, 0, 100, 100);
		queue_prim(CMD_LINE, -300, -40, 400, 140);
		queue_prim(CMD_LINE, 10, -200, 60, 300);
		// bounding box overlaps but the line misses the corner
		queue_prim(CMD_LINE, -150, 100, -50, 250);
		queue_prim(CMD_LINE, -32768, -32768, 32767, 32767);
		queue_prim(CMD_LINE, 32767, -32768, -32768, 32767);
		queue_prim(CMD_LINE, 300, 300, 400, 500);
		drain();

		// Without exact clipping diagonals pass untouched; horizontals and rectangles still clip
		set_clip(-100, -50, 200, 150, 1'b1, 1'b0);
		queue_prim(CMD_LINE, -300, -40, 400, 140);
		queue_prim(CMD_LINE, -500, 0, 500, 0);
		queue_prim(CMD_RECT, -300, -300, 100, 100);
		drain();

		// Inverted clip box rejects everything
		set_clip(100, 0, -100, 50, 1'b1, 1'b1);
		queue_prim(CMD_RECT, 0, 0, 10, 10);
		queue_prim(CMD_LINE, 0, 0, 10, 10);
		drain();

		// Random phases over several clip settings and idle patterns
		bx = $urandom_range(0, 2000) - 1000;
		by = $urandom_range(0, 2000) - 1000;
		random_phase(bx, by, bx + int'($urandom_range(0, 1500)),
		             by + int'($urandom_range(0, 1500)), 1'b1, 1'b1, 0, 0);
		random_phase(-32768, -32768, 32767, 32767, 1'b1, 1'b1, 54, 0);
		bx = $urandom_range(0, 2000) - 1000;
		by = $urandom_range(0, 2000) - 1000;
		random_phase(bx, by, bx + int'($urandom_range(0, 1500)),
		             by + int'($urandom_range(0, 1500)), 1'b1, 1'b0, 0, 54);
		random_phase(bx + int'($urandom_range(1, 500)), by, bx, by + 300, 1'b1, 1'b1, 29, 29);
		random_phase(bx, by, bx + 700, by + 400, 1'b0, 1'b1, 0, 0);
		random_phase(32767, 32767, -32768, -32768, 1'b1, 1'b1, 54, 0);
		bx = $urandom_range(0, 2000) - 1000;
		by = $urandom_range(0, 2000) - 1000;
		random_phase(bx, by, bx, by, 1'b1, 1'b1, 0, 54);
		random_phase(bx - 20, by - 10, bx + 30, by + 15, 1'b1, 1'b1, 29, 29);

		// Back-pressure: stall the receiver long enough to fill the block
		set_clip(-200, -200, 300, 250, 1'b1, 1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (i = 0; i < PRESSURE_ITEMS; i++) prim_q.push_back(random_prim());
		@(posedge clk);
		hold_req <= hold_req + 1;
		drain();

		if (mismatches == 0 && clipped_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
src/lrc_pkg.sv
src/line_rect_clip_engine_top.sv
src/lrc_checker.sv
tb/line_rect_clip_engine_top_test.sv
